@@ src/taqc_pkg.sv @@
// Shared types and codes for the tree ancestor query and check block.
package taqc_pkg;

  // Width of the node index fields on the input channel
  localparam int unsigned FIELD_W = 6;

  // Command codes carried in the cmd field
  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_CHECK = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  // Source of the column memory read address
  typedef enum logic [1:0] {
    RD_DEST = 2'd0,
    RD_SCAN = 2'd1,
    RD_WALK = 2'd2
  } rd_src_t;

  // Result to be captured when a command finishes
  typedef enum logic [1:0] {
    RES_ZERO = 2'd0,
    RES_ERR  = 2'd1,
    RES_TRUE = 2'd2,
    RES_TREE = 2'd3
  } res_sel_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic     ld_item;
    logic     rd_en;
    rd_src_t  rd_src;
    logic     wr_en;
    logic     chk_clr;
    logic     chk_acc;
    logic     col_inc;
    logic     walk_init;
    logic     walk_step;
    logic     res_ld;
    res_sel_t res_sel;
    logic     out_ld;
  } taqc_ctl_t;

  // Status from the datapath to the controller
  typedef struct packed {
    cmd_t cmd;
    logic range_err;
    logic col_end;
    logic walk_hit;
    logic walk_lim;
    logic no_parent;
  } taqc_sts_t;

endpackage

@@ src/taqc_in_if.sv @@
// Input channel: command items with valid/ready handshake.
interface taqc_in_if
  import taqc_pkg::*;
();
  logic               valid;
  logic               ready;
  cmd_t               cmd;
  logic [FIELD_W-1:0] from_node;
  logic [FIELD_W-1:0] to_node;
  logic               edge_bit;

  modport source (output valid, output cmd, output from_node, output to_node,
                  output edge_bit, input ready);
  modport sink   (input valid, input cmd, input from_node, input to_node,
                  input edge_bit, output ready);
endinterface

@@ src/taqc_out_if.sv @@
// Result channel: status and answer with valid/ready handshake.
interface taqc_out_if;
  logic valid;
  logic ready;
  logic status;
  logic answer;

  modport source (output valid, output status, output answer, input ready);
  modport sink   (input valid, input status, input answer, output ready);
endinterface

@@ src/taqc_ctrl.sv @@
// Controller state machine: sequences write, check and query commands.
module taqc_ctrl
  import taqc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      out_ready,
  output logic      out_valid,
  input  taqc_sts_t sts,
  output taqc_ctl_t ctl
);

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_DECODE  = 8'b0000_0010,
    S_WR_WB   = 8'b0000_0100,
    S_CHK     = 8'b0000_1000,
    S_CHK_END = 8'b0001_0000,
    S_Q_TEST  = 8'b0010_0000,
    S_Q_STEP  = 8'b0100_0000,
    S_DONE    = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    ctl.rd_src  = RD_DEST;
    ctl.res_sel = RES_ZERO;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.ld_item = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts.cmd)
          CMD_WRITE: begin
            if (sts.range_err) begin
              ctl.res_ld  = 1'b1;
              ctl.res_sel = RES_ERR;
              state_nxt   = S_DONE;
            end else begin
              ctl.rd_en  = 1'b1;
              ctl.rd_src = RD_DEST;
              state_nxt  = S_WR_WB;
            end
          end
          CMD_CHECK: begin
            ctl.chk_clr = 1'b1;
            ctl.rd_en   = 1'b1;
            ctl.rd_src  = RD_SCAN;
            ctl.col_inc = 1'b1;
            state_nxt   = S_CHK;
          end
          CMD_QUERY: begin
            if (sts.range_err) begin
              ctl.res_ld  = 1'b1;
              ctl.res_sel = RES_ERR;
              state_nxt   = S_DONE;
            end else begin
              ctl.walk_init = 1'b1;
              state_nxt     = S_Q_TEST;
            end
          end
          CMD_NONE: begin
            ctl.res_ld  = 1'b1;
            ctl.res_sel = RES_ZERO;
            state_nxt   = S_DONE;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_WR_WB: begin
        ctl.wr_en   = 1'b1;
        ctl.res_ld  = 1'b1;
        ctl.res_sel = RES_ZERO;
        state_nxt   = S_DONE;
      end
      S_CHK: begin
        ctl.chk_acc = 1'b1;
        if (sts.col_end) begin
          state_nxt = S_CHK_END;
        end else begin
          ctl.rd_en   = 1'b1;
          ctl.rd_src  = RD_SCAN;
          ctl.col_inc = 1'b1;
        end
      end
      S_CHK_END: begin
        ctl.res_ld  = 1'b1;
        ctl.res_sel = RES_TREE;
        state_nxt   = S_DONE;
      end
      S_Q_TEST: begin
        if (sts.walk_hit) begin
          ctl.res_ld  = 1'b1;
          ctl.res_sel = RES_TRUE;
          state_nxt   = S_DONE;
        end else if (sts.walk_lim) begin
          ctl.res_ld  = 1'b1;
          ctl.res_sel = RES_ZERO;
          state_nxt   = S_DONE;
        end else begin
          ctl.rd_en  = 1'b1;
          ctl.rd_src = RD_WALK;
          state_nxt  = S_Q_STEP;
        end
      end
      S_Q_STEP: begin
        if (sts.no_parent) begin
          ctl.res_ld  = 1'b1;
          ctl.res_sel = RES_ZERO;
          state_nxt   = S_DONE;
        end else begin
          ctl.walk_step = 1'b1;
          state_nxt     = S_Q_TEST;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          ctl.out_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold the result valid until the transfer completes
  always_comb begin
    if (ctl.out_ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ src/taqc_dp.sv @@
// Datapath: column memory of parent bits, tree scan and ancestor walk.
module taqc_dp
  import taqc_pkg::*;
#(
  parameter int unsigned NODES = 16
)(
  input  logic               clk,
  input  logic               rst_n,
  input  taqc_ctl_t          ctl,
  output taqc_sts_t          sts,
  input  cmd_t               in_cmd,
  input  logic [FIELD_W-1:0] in_from_node,
  input  logic [FIELD_W-1:0] in_to_node,
  input  logic               in_edge_bit,
  output logic               out_status,
  output logic               out_answer
);

  localparam int unsigned NW = $clog2(NODES);
  localparam int unsigned SW = $clog2(NODES + 1);

  // Latched command item
  cmd_t          cmd_r;
  logic [NW-1:0] u_r;
  logic [NW-1:0] v_r;
  logic          edge_r;
  logic          err_r;
  logic          err_nxt;

  // Column memory: entry c holds the parent bits of child c
  logic [NODES-1:0] col_mem [NODES];
  logic [NODES-1:0] col_vld_r;
  logic [NODES-1:0] rdata_r;
  logic             rvld_r;
  logic [NODES-1:0] colword;
  logic [NODES-1:0] wdata;
  logic [NW-1:0]    rd_addr;

  // Scan and walk state
  logic [SW-1:0]    col_r;
  logic             multi_r;
  logic [NODES-1:0] child_r;
  logic [NODES-1:0] noparent_r;
  logic [NODES-1:0] roots;
  logic             tree_ok;
  logic [NW-1:0]    node_r;
  logic [SW-1:0]    steps_r;
  logic [NW-1:0]    par_idx;

  // Results
  logic res_status_r;
  logic res_answer_r;
  logic out_status_r;
  logic out_answer_r;

  // Range check on the incoming node fields
  assign err_nxt = ({1'b0, in_from_node} >= (FIELD_W + 1)'(NODES)) ||
                   ({1'b0, in_to_node}   >= (FIELD_W + 1)'(NODES));

  always_ff @(posedge clk) begin
    if (ctl.ld_item) begin
      cmd_r  <= in_cmd;
      u_r    <= in_from_node[NW-1:0];
      v_r    <= in_to_node[NW-1:0];
      edge_r <= in_edge_bit;
      err_r  <= err_nxt;
    end
  end

  // Pick the read address; a new scan starts at column zero
  always_comb begin
    unique case (ctl.rd_src)
      RD_DEST: rd_addr = v_r;
      RD_SCAN: rd_addr = ctl.chk_clr ? '0 : col_r[NW-1:0];
      RD_WALK: rd_addr = node_r;
      default: rd_addr = v_r;
    endcase
  end

  // Never-written columns read as empty
  assign colword = rvld_r ? rdata_r : '0;

  // Replace one parent bit of the column read back
  always_comb begin
    wdata      = colword;
    wdata[u_r] = edge_r;
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      col_mem[v_r] <= wdata;
    end
    if (ctl.rd_en) begin
      rdata_r <= col_mem[rd_addr];
      rvld_r  <= col_vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_vld_r <= '0;
    end else if (ctl.wr_en) begin
      col_vld_r[v_r] <= 1'b1;
    end
  end

  // Accumulate the tree check one column per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else if (ctl.chk_clr) begin
      col_r <= SW'(1);
    end else if (ctl.col_inc) begin
      col_r <= col_r + SW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.chk_clr) begin
      multi_r <= 1'b0;
      child_r <= '0;
    end else if (ctl.chk_acc) begin
      multi_r    <= multi_r || ((colword & (colword - NODES'(1))) != '0);
      child_r    <= child_r | colword;
      noparent_r <= {(colword == '0), noparent_r[NODES-1:1]};
    end
  end

  // Exactly one parentless node that has children, and no shared child
  assign roots   = noparent_r & child_r;
  assign tree_ok = !multi_r && (roots != '0) &&
                   ((roots & (roots - NODES'(1))) == '0);

  // Lowest-indexed parent of the column read back
  always_comb begin
    par_idx = '0;
    for (int i = NODES - 1; i >= 0; i--) begin
      if (colword[i]) begin
        par_idx = NW'(i);
      end
    end
  end

  // Advance the walk one parent at a time
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_r  <= '0;
      steps_r <= '0;
    end else if (ctl.walk_init) begin
      node_r  <= v_r;
      steps_r <= '0;
    end else if (ctl.walk_step) begin
      node_r  <= par_idx;
      steps_r <= steps_r + SW'(1);
    end
  end

  // Capture the result, then move it to the output register
  always_ff @(posedge clk) begin
    if (ctl.res_ld) begin
      case (ctl.res_sel)
        RES_ZERO: begin
          res_status_r <= 1'b0;
          res_answer_r <= 1'b0;
        end
        RES_ERR: begin
          res_status_r <= 1'b1;
          res_answer_r <= 1'b0;
        end
        RES_TRUE: begin
          res_status_r <= 1'b0;
          res_answer_r <= 1'b1;
        end
        RES_TREE: begin
          res_status_r <= 1'b0;
          res_answer_r <= tree_ok;
        end
        default: begin
          res_status_r <= 1'b0;
          res_answer_r <= 1'b0;
        end
      endcase
    end
    if (ctl.out_ld) begin
      out_status_r <= res_status_r;
      out_answer_r <= res_answer_r;
    end
  end

  assign out_status = out_status_r;
  assign out_answer = out_answer_r;

  assign sts.cmd       = cmd_r;
  assign sts.range_err = err_r;
  assign sts.col_end   = (col_r == SW'(NODES));
  assign sts.walk_hit  = (node_r == u_r);
  assign sts.walk_lim  = (steps_r == SW'(NODES));
  assign sts.no_parent = (colword == '0);

endmodule

@@ src/tree_ancestor_query_and_check_core.sv @@
// Top level of the tree ancestor query and check block.
// The block keeps a NODES-by-NODES parent/child bit matrix in a memory with
// one entry per child column, and works on one command at a time; each
// command gives exactly one result. A write reads the column and writes it
// back; a check reads one column per cycle over all NODES columns; a query
// walks at most NODES parent steps, each of which reads one column and picks
// its lowest parent, and stops early when it reaches the from node or a node
// with no parent. A write or query with a node out of range, and the unused
// command code, go straight to the result. The column memory has a single
// read port. Reset clears the matrix at once through per-column valid bits.
// A new command is taken as soon as the previous one has moved to the
// output register, even if that result has not yet been taken.
module tree_ancestor_query_and_check_core
  import taqc_pkg::*;
#(
  parameter int unsigned NODES = 16
)(
  input  logic        clk,
  input  logic        rst_n,
  taqc_in_if.sink     in_ch,
  taqc_out_if.source  out_ch
);

  taqc_ctl_t ctl;
  taqc_sts_t sts;

  taqc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .sts       (sts),
    .ctl       (ctl)
  );

  taqc_dp #(
    .NODES (NODES)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (ctl),
    .sts          (sts),
    .in_cmd       (in_ch.cmd),
    .in_from_node (in_ch.from_node),
    .in_to_node   (in_ch.to_node),
    .in_edge_bit  (in_ch.edge_bit),
    .out_status   (out_ch.status),
    .out_answer   (out_ch.answer)
  );

endmodule
